>>> rtl/u16u8_pkg.sv
package u16u8_pkg;

  // Request on the UTF-16LE side: one raw byte
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_req_t;

  // Request on the UTF-8 side: one encoded byte
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
  } out_req_t;

  localparam int MaxBytes  = 6;
  localparam int LenW      = 3;
  localparam int CpW       = 21;
  localparam int QueueDepth = 4;

  // All bytes produced by one input byte, in order
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [LenW-1:0]          len;
  } entry_t;

  localparam logic [CpW-1:0] CpRepl     = 21'h00FFFD;
  localparam logic [CpW-1:0] CpSuppBase = 21'h010000;
  localparam logic [5:0]     HiSurTag   = 6'b110110;
  localparam logic [5:0]     LoSurTag   = 6'b110111;

  // Number of UTF-8 bytes for a code point
  function automatic logic [LenW-1:0] enc_len(input logic [CpW-1:0] cp);
    logic [LenW-1:0] n;
    if (cp <= 21'h00007F)      n = 3'd1;
    else if (cp <= 21'h0007FF) n = 3'd2;
    else if (cp <= 21'h00FFFF) n = 3'd3;
    else                       n = 3'd4;
    return n;
  endfunction

  // UTF-8 bytes of a code point, first byte at index 0
  function automatic logic [3:0][7:0] enc_bytes(input logic [CpW-1:0] cp);
    logic [3:0][7:0] b;
    b = '0;
    if (cp <= 21'h00007F) begin
      b[0] = cp[7:0];
    end else if (cp <= 21'h0007FF) begin
      b[0] = {3'b110, cp[10:6]};
      b[1] = {2'b10, cp[5:0]};
    end else if (cp <= 21'h00FFFF) begin
      b[0] = {4'b1110, cp[15:12]};
      b[1] = {2'b10, cp[11:6]};
      b[2] = {2'b10, cp[5:0]};
    end else begin
      b[0] = {5'b11110, cp[20:18]};
      b[1] = {2'b10, cp[17:12]};
      b[2] = {2'b10, cp[11:6]};
      b[3] = {2'b10, cp[5:0]};
    end
    return b;
  endfunction

endpackage

>>> rtl/u16u8_front.sv
module u16u8_front import u16u8_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  input  in_req_t req,
  input  logic    q_full,
  output logic    req_stall,
  output logic    push,
  output entry_t  push_entry
);

  logic       pair_phase;
  logic [7:0] held_low_byte;
  logic [9:0] pending_high_bits;
  logic       pending_high_valid;

  logic       accept;
  logic [15:0] unit;
  logic       is_hi;
  logic       is_lo;
  logic       va, vb, vc;
  logic [CpW-1:0] cp_a, cp_b, cp_s0, cp_s1;
  logic       s0_v, s1_v;
  logic       pend_next_valid;
  logic [9:0] pend_next_bits;
  logic [LenW-1:0] len0, len1;
  logic [3:0][7:0] b0, b1;

  // Place slot 1 bytes right after slot 0 bytes
  function automatic logic [MaxBytes-1:0][7:0] merge(input logic [3:0][7:0] x0,
                                                     input logic [LenW-1:0] l0,
                                                     input logic [3:0][7:0] x1);
    logic [MaxBytes-1:0][7:0] r;
    logic [LenW-1:0] j;
    r = '0;
    for (int i = 0; i < MaxBytes; i++) begin
      j = LenW'(i) - l0;
      if (LenW'(i) < l0) r[i] = x0[i[1:0]];
      else               r[i] = x1[j[1:0]];
    end
    return r;
  endfunction

  assign req_stall = q_full;
  assign accept    = req_valid && !q_full;

  // Classify the completed code unit
  assign unit  = {req.in_byte, held_low_byte};
  assign is_hi = (unit[15:10] == HiSurTag);
  assign is_lo = (unit[15:10] == LoSurTag);

  // Up to three code points: pair result or break, fresh unit, end of stream
  always_comb begin
    va              = 1'b0;
    cp_a            = CpRepl;
    vb              = 1'b0;
    cp_b            = is_lo ? CpRepl : {5'd0, unit};
    pend_next_valid = pending_high_valid;
    pend_next_bits  = pending_high_bits;
    if (pair_phase) begin
      if (pending_high_valid && is_lo) begin
        va              = 1'b1;
        cp_a            = CpSuppBase + CpW'({pending_high_bits, unit[9:0]});
        pend_next_valid = 1'b0;
      end else begin
        va              = pending_high_valid;
        vb              = !is_hi;
        pend_next_valid = is_hi;
        if (is_hi) pend_next_bits = unit[9:0];
      end
    end
    vc = req.in_last && pend_next_valid;
  end

  // Pack the valid code points into two slots
  assign s0_v  = va || vb || vc;
  assign s1_v  = (va && vb) || (va && vc) || (vb && vc);
  assign cp_s0 = va ? cp_a : (vb ? cp_b : CpRepl);
  assign cp_s1 = (va && vb) ? cp_b : CpRepl;

  assign len0 = s0_v ? enc_len(cp_s0) : '0;
  assign len1 = s1_v ? enc_len(cp_s1) : '0;
  assign b0   = enc_bytes(cp_s0);
  assign b1   = enc_bytes(cp_s1);

  assign push_entry.bytes = merge(b0, len0, b1);
  assign push_entry.len   = len0 + len1;
  assign push             = accept && s0_v;

  // Pairing state
  always_ff @(posedge clk) begin
    if (rst) begin
      pair_phase         <= 1'b0;
      held_low_byte      <= '0;
      pending_high_bits  <= '0;
      pending_high_valid <= 1'b0;
    end else if (accept) begin
      if (req.in_last) begin
        pair_phase         <= 1'b0;
        held_low_byte      <= '0;
        pending_high_bits  <= '0;
        pending_high_valid <= 1'b0;
      end else begin
        pair_phase <= !pair_phase;
        if (!pair_phase) held_low_byte <= req.in_byte;
        pending_high_valid <= pend_next_valid;
        pending_high_bits  <= pend_next_bits;
      end
    end
  end

endmodule

>>> rtl/u16u8_queue.sv
module u16u8_queue import u16u8_pkg::*; #(
  parameter int Depth = QueueDepth
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output entry_t head,
  output logic   empty,
  output logic   full
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  entry_t        mem [Depth];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign empty = (count == '0);
  assign full  = (count == CW'(Depth));
  assign head  = mem[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_entry;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == AW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == AW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

>>> rtl/u16u8_back.sv
module u16u8_back import u16u8_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  entry_t   head,
  input  logic     empty,
  output logic     pop,
  output logic     res_valid,
  input  logic     res_stall,
  output out_req_t res
);

  logic [LenW-1:0] idx;
  logic            at_end;
  logic            take;

  assign res_valid    = !empty;
  assign take         = res_valid && !res_stall;
  assign at_end       = (idx == head.len - 1'b1);
  assign pop          = take && at_end;
  assign res.out_byte = head.bytes[idx];
  assign res.run_last = at_end;

  // Byte index within the head entry
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (take) begin
      idx <= at_end ? '0 : idx + 1'b1;
    end
  end

endmodule

>>> rtl/utf16le_to_utf8_transcoder.sv
// UTF-16LE to UTF-8 transcoder. One byte of the UTF-16LE stream is taken per
// cycle on the utf16 channel while the entry queue (QueueDepth entries) has room;
// each byte is classified at once and the 1 to 6 UTF-8 bytes it yields, if any,
// go into the queue as one entry. The serializer sends one UTF-8 byte per cycle
// on the utf8 channel while utf8_stall is low, with run_last marking the final
// byte caused by an input byte. Each entry is written to the registered queue
// before its bytes are sent. Surrogate pairs give 4-byte sequences; unpaired
// surrogates give U+FFFD; a trailing odd byte is dropped and all pairing state
// clears after a byte flagged in_last.
module utf16le_to_utf8_transcoder import u16u8_pkg::*; #(
  parameter int QDepth = QueueDepth
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     utf16_valid,
  output logic     utf16_stall,
  input  in_req_t  utf16_req,
  output logic     utf8_valid,
  input  logic     utf8_stall,
  output out_req_t utf8_req
);

  logic   push;
  entry_t push_entry;
  logic   pop;
  entry_t head;
  logic   empty;
  logic   full;

  u16u8_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (utf16_valid),
    .req        (utf16_req),
    .q_full     (full),
    .req_stall  (utf16_stall),
    .push       (push),
    .push_entry (push_entry)
  );

  u16u8_queue #(.Depth(QDepth)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (empty),
    .full       (full)
  );

  u16u8_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .res_valid (utf8_valid),
    .res_stall (utf8_stall),
    .res       (utf8_req)
  );

endmodule

>>> rtl/u16u8_checker.sv
module u16u8_checker import u16u8_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     utf16_valid,
  input logic     utf16_stall,
  input in_req_t  utf16_req,
  input logic     utf8_valid,
  input logic     utf8_stall,
  input out_req_t utf8_req
);

  // A stalled input request holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    utf16_valid && utf16_stall |=> utf16_valid && $stable(utf16_req))
    else $error("utf16 request changed while stalled");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    utf8_valid && utf8_stall |=> utf8_valid && $stable(utf8_req))
    else $error("utf8 request changed while stalled");

  // Nothing is queued right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !utf8_valid)
    else $error("utf8 valid after reset");

  // A multi-byte sequence is sent without gaps
  a_burst: assert property (@(posedge clk) disable iff (rst)
    utf8_valid && !utf8_stall && !utf8_req.run_last |=> utf8_valid)
    else $error("gap inside a utf8 burst");

  // The queue only fills after an accepted byte
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(utf16_stall) |-> $past(utf16_valid && !utf16_stall))
    else $error("utf16 stall rose without a request");

endmodule

bind utf16le_to_utf8_transcoder u16u8_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .utf16_valid (utf16_valid),
  .utf16_stall (utf16_stall),
  .utf16_req   (utf16_req),
  .utf8_valid  (utf8_valid),
  .utf8_stall  (utf8_stall),
  .utf8_req    (utf8_req)
);

>>> tb/utf16le_to_utf8_transcoder_tb.sv
`timescale 1ns / 100ps

module utf16le_to_utf8_transcoder_tb;
  import u16u8_pkg::*;

  localparam logic [20:0] ReplCp     = 21'h00FFFD;
  localparam logic [20:0] SuppBase   = 21'h010000;
  localparam logic [5:0]  HighSurTag = 6'b110110;
  localparam logic [5:0]  LowSurTag  = 6'b110111;
  localparam int          RandBytes  = 246;
  localparam int          HoldAfter  = 70;
  localparam int          HoldCycles = 80;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     utf16_valid = 1'b0;
  logic     utf16_stall;
  in_req_t  utf16_req = '0;
  logic     utf8_valid;
  logic     utf8_stall = 1'b0;
  out_req_t utf8_req;

  utf16le_to_utf8_transcoder uut (
    .clk         (clk),
    .rst         (rst),
    .utf16_valid (utf16_valid),
    .utf16_stall (utf16_stall),
    .utf16_req   (utf16_req),
    .utf8_valid  (utf8_valid),
    .utf8_stall  (utf8_stall),
    .utf8_req    (utf8_req)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Directed requests; rows with typed set carry their UTF-8 bytes, first byte in the MSBs
  typedef struct packed {
    logic        typed;
    logic [2:0]  n;
    logic [7:0]  b;
    logic        last;
    logic [47:0] o;
  } probe_t;

  localparam int ProbeRows = 24;
  probe_t probe_table [ProbeRows] = '{
    '{1'b1, 3'd0, 8'h00, 1'b0, 48'h0},              // U+0000
    '{1'b1, 3'd1, 8'h00, 1'b0, 48'h0},
    '{1'b1, 3'd0, 8'hFF, 1'b0, 48'h0},              // U+07FF, top of 2-byte range
    '{1'b1, 3'd2, 8'h07, 1'b0, 48'hDFBF_0000_0000},
    '{1'b0, 3'd0, 8'hFF, 1'b0, 48'h0},              // U+FFFF
    '{1'b0, 3'd0, 8'hFF, 1'b0, 48'h0},
    '{1'b1, 3'd0, 8'hFF, 1'b0, 48'h0},              // DBFF DFFF -> U+10FFFF
    '{1'b1, 3'd0, 8'hDB, 1'b0, 48'h0},
    '{1'b1, 3'd0, 8'hFF, 1'b0, 48'h0},
    '{1'b1, 3'd4, 8'hDF, 1'b0, 48'hF48FBFBF_0000},
    '{1'b1, 3'd0, 8'h00, 1'b0, 48'h0},              // lone low surrogate
    '{1'b1, 3'd3, 8'hDC, 1'b0, 48'hEFBFBD_000000},
    '{1'b1, 3'd0, 8'h00, 1'b0, 48'h0},              // high surrogate broken by 'A'
    '{1'b1, 3'd0, 8'hD8, 1'b0, 48'h0},
    '{1'b1, 3'd0, 8'h41, 1'b0, 48'h0},
    '{1'b1, 3'd4, 8'h00, 1'b0, 48'hEFBFBD41_0000},
    '{1'b1, 3'd0, 8'h00, 1'b0, 48'h0},              // high, high, stream end
    '{1'b1, 3'd0, 8'hD8, 1'b0, 48'h0},
    '{1'b1, 3'd0, 8'h00, 1'b0, 48'h0},
    '{1'b1, 3'd6, 8'hD8, 1'b1, 48'hEFBFBDEFBFBD},
    '{1'b1, 3'd0, 8'h00, 1'b0, 48'h0},              // pending high, then odd byte at end
    '{1'b1, 3'd0, 8'hD8, 1'b0, 48'h0},
    '{1'b1, 3'd3, 8'h7A, 1'b1, 48'hEFBFBD_000000},
    '{1'b1, 3'd0, 8'h41, 1'b1, 48'h0}               // odd byte alone, dropped
  };

  // Pairing state of the transcoder as predicted
  logic       low_held;
  logic [7:0] held_byte;
  logic [9:0] sur_bits;
  logic       sur_pending;
  out_req_t   run_bytes[$];
  out_req_t   expected_utf8[$];

  int mismatches  = 0;
  int sent_count  = 0;
  bit src_idle    = 1'b1;
  bit sink_idle   = 1'b1;
  bit hold_done   = 1'b0;
  int stall_left  = 0;

  task automatic flag_mismatch(input string what);
    $display("%0t ns: %s", $time, what);
    mismatches++;
  endtask

  // UTF-8 encoding of one code point onto the current run
  function automatic void encode_cp(input logic [20:0] cp);
    if (cp <= 21'h7F) begin
      run_bytes.push_back({cp[7:0], 1'b0});
    end else if (cp <= 21'h7FF) begin
      run_bytes.push_back({3'b110, cp[10:6], 1'b0});
      run_bytes.push_back({2'b10, cp[5:0], 1'b0});
    end else if (cp <= 21'hFFFF) begin
      run_bytes.push_back({4'b1110, cp[15:12], 1'b0});
      run_bytes.push_back({2'b10, cp[11:6], 1'b0});
      run_bytes.push_back({2'b10, cp[5:0], 1'b0});
    end else begin
      run_bytes.push_back({5'b11110, cp[20:18], 1'b0});
      run_bytes.push_back({2'b10, cp[17:12], 1'b0});
      run_bytes.push_back({2'b10, cp[11:6], 1'b0});
      run_bytes.push_back({2'b10, cp[5:0], 1'b0});
    end
  endfunction

  // A unit with nothing pending: high surrogates wait, low ones are replaced
  function automatic void take_unit(input logic [15:0] unit);
    if (unit[15:10] == HighSurTag) begin
      sur_bits    = unit[9:0];
      sur_pending = 1'b1;
    end else if (unit[15:10] == LowSurTag) begin
      encode_cp(ReplCp);
    end else begin
      encode_cp({5'd0, unit});
    end
  endfunction

  // Predicted UTF-8 bytes for one accepted input byte, left in run_bytes
  function automatic void transcode_byte(input in_req_t r);
    logic [15:0] unit;
    run_bytes.delete();
    if (!low_held) begin
      held_byte = r.in_byte;
      low_held  = 1'b1;
    end else begin
      unit     = {r.in_byte, held_byte};
      low_held = 1'b0;
      if (sur_pending) begin
        sur_pending = 1'b0;
        if (unit[15:10] == LowSurTag) begin
          encode_cp(SuppBase + {1'b0, sur_bits, unit[9:0]});
        end else begin
          encode_cp(ReplCp);
          take_unit(unit);
        end
      end else begin
        take_unit(unit);
      end
    end
    // stream end flushes a pending high surrogate and clears everything
    if (r.in_last) begin
      if (sur_pending) encode_cp(ReplCp);
      low_held    = 1'b0;
      held_byte   = '0;
      sur_bits    = '0;
      sur_pending = 1'b0;
    end
    if (run_bytes.size() > 0) run_bytes[run_bytes.size() - 1].run_last = 1'b1;
  endfunction

  function automatic int idle_len();
    if ($urandom_range(9) == 0) return $urandom_range(30, 10);
    return $urandom_range(3, 1);
  endfunction

  function automatic logic [9:0] pick_sur();
    int pick;
    pick = $urandom_range(7);
    if (pick == 0) return 10'h000;
    if (pick == 1) return 10'h3FF;
    return 10'($urandom_range(10'h3FF));
  endfunction

  // Offer one request on the utf16 side and record what it should produce
  task automatic send_byte(input in_req_t r, input logic typed, input logic [2:0] n,
                           input logic [47:0] o);
    int gap;
    int i;
    gap = (src_idle && $urandom_range(99) < 35) ? idle_len() : 0;
    if (gap > 0) begin
      utf16_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    utf16_valid <= 1'b1;
    utf16_req   <= r;
    do @(posedge clk); while (utf16_stall);
    transcode_byte(r);
    if (typed) begin
      for (i = 0; i < n; i++) expected_utf8.push_back({o[47 - 8 * i -: 8], i == n - 1});
    end else begin
      for (i = 0; i < run_bytes.size(); i++) expected_utf8.push_back(run_bytes[i]);
    end
    sent_count++;
  endtask

  task automatic check_utf8(input out_req_t got);
    out_req_t want;
    if (expected_utf8.size() == 0) begin
      flag_mismatch($sformatf("unexpected utf8 request %02h run_last %0b",
                              got.out_byte, got.run_last));
    end else begin
      want = expected_utf8.pop_front();
      if (got.out_byte !== want.out_byte)
        flag_mismatch($sformatf("out_byte %02h, want %02h", got.out_byte, want.out_byte));
      if (got.run_last !== want.run_last)
        flag_mismatch($sformatf("run_last %0b, want %0b on byte %02h",
                                got.run_last, want.run_last, want.out_byte));
    end
  endtask

  // utf8 side: check accepted requests, then pick the next stall
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && utf8_valid && !utf8_stall) check_utf8(utf8_req);
      // one long hold-off so the entry queue fills and the input stalls
      if (!hold_done && sent_count >= HoldAfter) begin
        hold_done  = 1'b1;
        stall_left = HoldCycles;
      end
      if ($urandom_range(63) == 0) sink_idle = !sink_idle;
      if (stall_left > 0) begin
        stall_left--;
        utf8_stall <= 1'b1;
      end else if (sink_idle && $urandom_range(99) < 25) begin
        stall_left = idle_len() - 1;
        utf8_stall <= 1'b1;
      end else begin
        utf8_stall <= 1'b0;
      end
    end
  end

  // utf16 side: directed table, then random streams
  initial begin
    int row;
    int k;
    int nu;
    int kind;
    int tail;
    logic [15:0] units[$];
    in_req_t r;
    low_held    = 1'b0;
    held_byte   = '0;
    sur_bits    = '0;
    sur_pending = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (row = 0; row < ProbeRows; row++) begin
      send_byte(in_req_t'({probe_table[row].b, probe_table[row].last}),
                probe_table[row].typed, probe_table[row].n, probe_table[row].o);
    end

    while (sent_count < ProbeRows + RandBytes) begin
      if ($urandom_range(3) == 0) src_idle = !src_idle;
      if ($urandom_range(9) == 0) begin
        // raw noise bytes
        repeat ($urandom_range(8, 1)) begin
          r.in_byte = 8'($urandom_range(255));
          r.in_last = ($urandom_range(7) == 0);
          send_byte(r, 1'b0, '0, '0);
        end
      end else begin
        // well-formed stream with random units, sometimes spoiled by lone surrogates
        units.delete();
        nu = $urandom_range(8, 1);
        repeat (nu) begin
          kind = $urandom_range(99);
          if (kind < 20) begin
            units.push_back(16'($urandom_range(16'h007F)));
          end else if (kind < 35) begin
            units.push_back(16'($urandom_range(16'h07FF, 16'h0080)));
          end else if (kind < 50) begin
            units.push_back(16'(kind[0] ? $urandom_range(16'hD7FF, 16'h0800)
                                        : $urandom_range(16'hFFFF, 16'hE000)));
          end else if (kind < 82) begin
            units.push_back({HighSurTag, pick_sur()});
            units.push_back({LowSurTag, pick_sur()});
          end else if (kind < 91) begin
            units.push_back({HighSurTag, pick_sur()});
          end else begin
            units.push_back({LowSurTag, pick_sur()});
          end
        end
        // ending: flagged on the last unit, an odd trailing byte, or none
        tail = $urandom_range(99);
        for (k = 0; k < units.size(); k++) begin
          send_byte(in_req_t'({units[k][7:0], 1'b0}), 1'b0, '0, '0);
          send_byte(in_req_t'({units[k][15:8], tail < 75 && k == units.size() - 1}),
                    1'b0, '0, '0);
        end
        if (tail >= 75 && tail < 88) begin
          r.in_byte = 8'($urandom_range(255));
          r.in_last = 1'b1;
          send_byte(r, 1'b0, '0, '0);
        end
      end
    end
    utf16_valid <= 1'b0;

    while (expected_utf8.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("utf16le_to_utf8_transcoder_tb: clean");
    end else begin
      $display("utf16le_to_utf8_transcoder_tb: errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #1000000;
    $display("utf16le_to_utf8_transcoder_tb: errors");
    $finish;
  end

endmodule

>>> files.f
rtl/u16u8_pkg.sv
rtl/u16u8_front.sv
rtl/u16u8_queue.sv
rtl/u16u8_back.sv
rtl/utf16le_to_utf8_transcoder.sv
rtl/u16u8_checker.sv
tb/utf16le_to_utf8_transcoder_tb.sv
